>>> rtl/utf8dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Shared types and constants of the UTF-8 decoder with replacement.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

    localparam int CP_W       = 21;
    localparam int COUNT_W    = 3;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h010000;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [5:0] CONT_MASK = 6'h3F;

    // Continuation bytes a lead asks for
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // One command from front to back: emit count words, all U+FFFD except
    // the last, which carries code.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [CP_W-1:0]    code;
        logic               eot;
    } cmd_t;

endpackage

>>> rtl/utf8_decoder_with_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement_unit
// UTF-8 byte stream in, Unicode code points out, bad input as U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per word; tlast marks the final byte of the
//   text. m_axis carries one code point per word; tlast marks the last word
//   caused by an input byte, tuser marks the final word of the whole text.
//   A byte that only opens or extends a sequence gives no word; a byte can
//   give up to four words (replacement run on a broken sequence).
// Path: the command for a byte is written into the queue when the byte is
//   taken, then loaded into the output register, which presents the word.
// Throughput: one byte per cycle while each byte yields at most one word and
//   m_axis_tready stays high; a byte yielding several words holds the output
//   side until its run has gone out, and the command queue (QUEUE_DEPTH
//   entries) absorbs the front while it drains.
// Reset: rst_n clears the open sequence, empties the queue and drops any
//   word not yet delivered.
// Stall: with m_axis_tready low, the current word holds; the input keeps
//   taking bytes until the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tlast,   // last_of_run
    output logic [0:0]  m_axis_tuser    // [0] text_done
);
    import utf8dec_pkg::*;

    logic        accept;
    logic        push;
    cmd_t        push_cmd;
    logic        full;
    logic        pop;
    logic        head_valid;
    cmd_t        head_cmd;
    logic [20:0] code_point;
    logic        text_done;

    // Take a byte whenever the queue has room for its command
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    utf8dec_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .push        (push),
        .cmd         (push_cmd)
    );

    utf8dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    utf8dec_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .code_point  (code_point),
        .last_of_run (m_axis_tlast),
        .text_done   (text_done)
    );

    // Pack the code point into the byte-aligned data word
    assign m_axis_tdata = {3'b000, code_point};
    assign m_axis_tuser = text_done;

endmodule

>>> rtl/utf8dec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dec_front
// Classify each input byte, track the open sequence and issue a command.
// ----------------------------------------------------------------------------
module utf8dec_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_text,
    output logic                push,
    output utf8dec_pkg::cmd_t   cmd
);
    import utf8dec_pkg::*;

    logic [1:0]      seq_len_reg, seq_len_next;
    logic [1:0]      collected_reg, collected_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    logic            seq_open;
    logic            is_cont;
    logic [1:0]      col_inc;
    logic [CP_W-1:0] ext_code;
    logic [CP_W-1:0] min_cp;
    logic            bad_cp;
    logic [1:0]      lead_len;
    logic [CP_W-1:0] lead_bits;
    logic [CP_W-1:0] lead_code;
    logic [COUNT_W-1:0] base_count;

    always_comb
    begin
        seq_open = (seq_len_reg != SEQ_NONE);
        is_cont  = (data_byte[7:6] == 2'b10);
        col_inc  = collected_reg + 2'd1;
        ext_code = {partial_reg[CP_W-7:0], data_byte[5:0] & CONT_MASK};

        case (seq_len_reg)
            SEQ_TWO:   min_cp = MIN_TWO_BYTE;
            SEQ_THREE: min_cp = MIN_THREE_BYTE;
            default:   min_cp = MIN_FOUR_BYTE;
        endcase
        bad_cp = (ext_code < min_cp) || (ext_code > MAX_SCALAR) ||
                 ((ext_code >= SURR_LO) && (ext_code <= SURR_HI));

        // Lead decode
        lead_len  = SEQ_NONE;
        lead_bits = '0;
        lead_code = REPLACEMENT_CP;
        if (!data_byte[7])
        begin
            lead_code = {13'd0, data_byte};
        end
        else if ((data_byte >= LEAD2_LO) && (data_byte <= LEAD2_HI))
        begin
            lead_len  = SEQ_TWO;
            lead_bits = {16'd0, data_byte[4:0]};
        end
        else if ((data_byte >= LEAD3_LO) && (data_byte <= LEAD3_HI))
        begin
            lead_len  = SEQ_THREE;
            lead_bits = {17'd0, data_byte[3:0]};
        end
        else if ((data_byte >= LEAD4_LO) && (data_byte <= LEAD4_HI))
        begin
            lead_len  = SEQ_FOUR;
            lead_bits = {18'd0, data_byte[2:0]};
        end

        // Flushing an open sequence gives the lead plus each continuation taken
        base_count = seq_open ? ({1'b0, collected_reg} + 3'd1) : 3'd0;
    end

    always_comb
    begin
        seq_len_next   = seq_len_reg;
        collected_next = collected_reg;
        partial_next   = partial_reg;
        cmd.count      = '0;
        cmd.code       = REPLACEMENT_CP;
        cmd.eot        = end_of_text;
        if (accept)
        begin
            if (seq_open && is_cont)
            begin
                if (col_inc >= seq_len_reg)
                begin
                    cmd.count      = 3'd1;
                    cmd.code       = bad_cp ? REPLACEMENT_CP : ext_code;
                    seq_len_next   = SEQ_NONE;
                    collected_next = '0;
                    partial_next   = '0;
                end
                else if (end_of_text)
                begin
                    cmd.count      = {1'b0, col_inc} + 3'd1;
                    seq_len_next   = SEQ_NONE;
                    collected_next = '0;
                    partial_next   = '0;
                end
                else
                begin
                    collected_next = col_inc;
                    partial_next   = ext_code;
                end
            end
            else
            begin
                seq_len_next   = SEQ_NONE;
                collected_next = '0;
                partial_next   = '0;
                if (lead_len != SEQ_NONE)
                begin
                    if (end_of_text)
                    begin
                        cmd.count = base_count + 3'd1;
                    end
                    else
                    begin
                        cmd.count    = base_count;
                        seq_len_next = lead_len;
                        partial_next = lead_bits;
                    end
                end
                else
                begin
                    cmd.count = base_count + 3'd1;
                    cmd.code  = lead_code;
                end
            end
        end
        push = accept && (cmd.count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg   <= SEQ_NONE;
            collected_reg <= '0;
            partial_reg   <= '0;
        end
        else
        begin
            seq_len_reg   <= seq_len_next;
            collected_reg <= collected_next;
            partial_reg   <= partial_next;
        end
    end

endmodule

>>> rtl/utf8dec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dec_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module utf8dec_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  utf8dec_pkg::cmd_t   push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output utf8dec_pkg::cmd_t   head_cmd
);
    import utf8dec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    always_comb
    begin
        full       = (count_reg == CNT_W'(DEPTH));
        head_valid = (count_reg != '0);
        head_cmd   = mem[rd_ptr_reg];
        do_pop     = pop && head_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/utf8dec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dec_back
// Expand each command into its run of code point words.
// ----------------------------------------------------------------------------
module utf8dec_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  utf8dec_pkg::cmd_t   head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [20:0]         code_point,
    output logic                last_of_run,
    output logic                text_done
);
    import utf8dec_pkg::*;

    logic               valid_reg, valid_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic [CP_W-1:0]    code_reg, code_next;
    logic               eot_reg, eot_next;
    logic               advance;

    always_comb
    begin
        out_valid   = valid_reg;
        last_of_run = (remain_reg == 3'd1);
        code_point  = last_of_run ? code_reg : REPLACEMENT_CP;
        text_done   = last_of_run && eot_reg;

        // Load the next command once the current run has gone out
        advance = !valid_reg || (out_ready && last_of_run);
        pop     = advance && head_valid;

        valid_next  = valid_reg;
        remain_next = remain_reg;
        code_next   = code_reg;
        eot_next    = eot_reg;
        if (advance)
        begin
            valid_next  = head_valid;
            remain_next = head_cmd.count;
            code_next   = head_cmd.code;
            eot_next    = head_cmd.eot;
        end
        else if (out_ready)
        begin
            remain_next = remain_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        eot_reg  <= eot_next;
    end

endmodule

>>> tb/utf8_decoder_with_replacement_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement_unit_test
// Self-checking bench for the UTF-8 decoder with U+FFFD replacement.
// ----------------------------------------------------------------------------
// Bytes go in on s_axis, code points come out on m_axis. A predictor that
// tracks the open sequence computes the words each accepted byte must give;
// a checker process compares every delivered word in order. Directed tests
// cover the code point extremes, invalid leads, stray continuations,
// overlong, surrogate and out-of-range sequences, broken sequences and the
// end-of-text flush. Random text (mostly well-formed characters, some
// rejected or truncated sequences and raw noise) then runs under several
// idle and stall mixes, and one test holds the output off long enough for
// the input to back up.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement_unit_test;

    import utf8dec_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // One expected output word
    typedef struct packed {
        logic [CP_W-1:0] code;
        logic            last;
        logic            done;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] data_byte
    logic        s_axis_tlast;    // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [20:0] code_point, [23:21] zero
    logic        m_axis_tlast;    // last_of_run
    logic [0:0]  m_axis_tuser;    // [0] text_done

    // Predictor state: continuation bytes the open sequence needs, taken so
    // far, and the code point bits gathered
    logic [1:0]      open_len;
    logic [1:0]      taken;
    logic [CP_W-1:0] partial_cp;
    logic [CP_W-1:0] pending_run[$];

    point_t expected_points[$];

    int error_count;
    int items_sent;
    int words_checked;
    int replacements_seen;
    int input_stall_cycles;
    int cycle_count;

    // Idle mix, in cycles of a hundred
    int send_idle_pct;
    int recv_stall_pct;
    // Cycles the receiver still holds off, counted down by the checker process
    int holdoff_left;

    utf8_decoder_with_replacement_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Append one code point to the run of the current byte
    task automatic queue_code(input logic [CP_W-1:0] cp);
        pending_run.insert(pending_run.size(), cp);
    endtask

    task automatic close_sequence();
        open_len   = SEQ_NONE;
        taken      = 2'd0;
        partial_cp = '0;
    endtask

    // Give one replacement for the lead and one per continuation taken
    task automatic flush_open();
        for (int i = 0; i <= taken; i++)
            queue_code(REPLACEMENT_CP);
        close_sequence();
    endtask

    task automatic decode_lead(input logic [7:0] b);
        taken = 2'd0;
        if (!b[7])
            queue_code({13'd0, b});
        else if (b >= LEAD2_LO && b <= LEAD2_HI)
        begin
            open_len   = SEQ_TWO;
            partial_cp = {16'd0, b[4:0]};
        end
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
        begin
            open_len   = SEQ_THREE;
            partial_cp = {17'd0, b[3:0]};
        end
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
        begin
            open_len   = SEQ_FOUR;
            partial_cp = {18'd0, b[2:0]};
        end
        else
            queue_code(REPLACEMENT_CP);
    endtask

    // Work out the words one accepted byte causes and queue them
    task automatic predict_byte(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] floor_cp;
        point_t          p;
        pending_run.delete();
        if (open_len != SEQ_NONE && b[7:6] == 2'b10)
        begin
            partial_cp = {partial_cp[CP_W-7:0], b[5:0] & CONT_MASK};
            taken      = taken + 2'd1;
            if (taken >= open_len)
            begin
                case (open_len)
                    SEQ_TWO:   floor_cp = MIN_TWO_BYTE;
                    SEQ_THREE: floor_cp = MIN_THREE_BYTE;
                    default:   floor_cp = MIN_FOUR_BYTE;
                endcase
                if (partial_cp < floor_cp || partial_cp > MAX_SCALAR ||
                    (partial_cp >= SURR_LO && partial_cp <= SURR_HI))
                    queue_code(REPLACEMENT_CP);
                else
                    queue_code(partial_cp);
                close_sequence();
            end
        end
        else
        begin
            // A non-continuation breaks any open sequence, then starts fresh
            if (open_len != SEQ_NONE)
                flush_open();
            decode_lead(b);
        end
        if (eot && open_len != SEQ_NONE)
            flush_open();
        foreach (pending_run[k])
        begin
            p.code = pending_run[k];
            p.last = (k == pending_run.size() - 1);
            p.done = p.last && eot;
            expected_points.insert(expected_points.size(), p);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one byte, hold it until taken, then predict
    // ------------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        items_sent++;
        predict_byte(b, eot);
    endtask

    function automatic logic pick_eot();
        return ($urandom_range(23) == 0);
    endfunction

    // Send the first `count` bytes of the `len`-byte encoding of cp; the bit
    // pattern is packed as-is, so out-of-range values yield rejected sequences
    task automatic send_char(input logic [CP_W-1:0] cp, input int len, input int count);
        logic [7:0] bytes_out[4];
        case (len)
            1: bytes_out[0] = {1'b0, cp[6:0]};
            2:
            begin
                bytes_out[0] = {3'b110, cp[10:6]};
                bytes_out[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                bytes_out[0] = {4'b1110, cp[15:12]};
                bytes_out[1] = {2'b10, cp[11:6]};
                bytes_out[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                bytes_out[0] = {5'b11110, cp[20:18]};
                bytes_out[1] = {2'b10, cp[17:12]};
                bytes_out[2] = {2'b10, cp[11:6]};
                bytes_out[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < count; i++)
            send_byte(bytes_out[i], pick_eot());
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check each delivered word, then pick the next tready
    // ------------------------------------------------------------------------

    task automatic check_word();
        point_t want;
        if (expected_points.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected word, expected none, got code %h last %b done %b",
                     $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            return;
        end
        want = expected_points.pop_front();
        words_checked++;
        if (want.code == REPLACEMENT_CP)
            replacements_seen++;
        if (m_axis_tdata !== {3'b000, want.code})
        begin
            error_count++;
            $display("%0t: code point mismatch, expected %h, got %h",
                     $time, {3'b000, want.code}, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last)
        begin
            error_count++;
            $display("%0t: last_of_run mismatch, expected %b, got %b",
                     $time, want.last, m_axis_tlast);
        end
        if (m_axis_tuser[0] !== want.done)
        begin
            error_count++;
            $display("%0t: text_done mismatch, expected %b, got %b",
                     $time, want.done, m_axis_tuser[0]);
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_word();
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if it never drains
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("utf8_decoder_with_replacement_unit_test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Lowest and highest code points and the one- to two-byte boundary; text_done on a completing byte
    task automatic test_valid_sequences();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // Stray continuation, invalid leads
    task automatic test_invalid_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Complete but overlong, surrogate and above U+10FFFF
    task automatic test_rejected_sequences();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Four-byte lead with two continuations broken by ASCII: four words
    task automatic test_broken_sequence();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    // Broken sequence whose breaking byte opens a new one at end of text:
    // three replacements for the break, one more for the flush
    task automatic test_end_of_text();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE1, 1'b1);
    endtask

    task automatic test_random_text(input int idle_pct, input int stall_pct, input int n_items);
        int              start_count;
        int              kind;
        int              len;
        logic [CP_W-1:0] cp;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = items_sent;
        while (items_sent - start_count < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                // Well-formed character of random length and content
                len = $urandom_range(4, 1);
                case (len)
                    1:       cp = CP_W'($urandom_range(32'h7F));
                    2:       cp = CP_W'($urandom_range(32'h7FF, 32'h80));
                    3:       cp = CP_W'($urandom_range(32'hFFFF, 32'h800));
                    default: cp = CP_W'($urandom_range(32'h10FFFF, 32'h10000));
                endcase
                send_char(cp, len, len);
            end
            else if (kind < 72)
            begin
                // Complete sequence the decoder must reject
                case ($urandom_range(3))
                    0:
                    begin
                        len = 3;
                        cp  = CP_W'($urandom_range(32'h7FF));
                    end
                    1:
                    begin
                        len = 4;
                        cp  = CP_W'($urandom_range(32'hFFFF));
                    end
                    2:
                    begin
                        len = 3;
                        cp  = CP_W'($urandom_range(32'hDFFF, 32'hD800));
                    end
                    default:
                    begin
                        len = 4;
                        cp  = CP_W'($urandom_range(32'h13FFFF, 32'h110000));
                    end
                endcase
                send_char(cp, len, len);
            end
            else if (kind < 84)
            begin
                // Truncated sequence; whatever follows breaks it
                len = $urandom_range(4, 2);
                cp  = CP_W'($urandom_range(32'h10FFFF, 32'h80));
                send_char(cp, len, int'($urandom_range(len - 1, 1)));
            end
            else
                send_byte(8'($urandom_range(255)), pick_eot());
        end
    endtask

    // Hold the output off while the sender keeps offering bytes, several of
    // them causing replacement runs, so the queue fills and the input stalls
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 300;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 3 == 2)
                send_byte(8'(8'h41 + i), 1'b0);
            else
                send_byte(8'hE2, 1'b0);
        end
        send_byte(8'hF0, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = 8'h00;
        s_axis_tlast       = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        holdoff_left       = 0;
        error_count        = 0;
        items_sent         = 0;
        words_checked      = 0;
        replacements_seen  = 0;
        input_stall_cycles = 0;
        close_sequence();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_sequences();
        test_invalid_bytes();
        test_rejected_sequences();
        test_broken_sequence();
        test_end_of_text();

        // Random text under each idle mix
        test_random_text(0, 0, 125);
        test_random_text(87, 0, 125);
        test_random_text(0, 87, 125);
        test_random_text(32, 32, 125);

        test_output_holdoff();

        // Drop valid, drain, then allow the pipeline latency to settle
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Decoded %0d bytes into %0d checked words, %0d of them U+FFFD replacements;",
                 items_sent, words_checked, replacements_seen);
        $display("input held off for %0d cycles under output backpressure.",
                 input_stall_cycles);
        if (error_count == 0)
            $display("utf8_decoder_with_replacement_unit_test passed");
        else
            $display("utf8_decoder_with_replacement_unit_test failed");
        $finish;
    end

endmodule

>>> utf8_decoder_with_replacement_unit.f
rtl/utf8dec_pkg.sv
rtl/utf8dec_front.sv
rtl/utf8dec_queue.sv
rtl/utf8dec_back.sv
rtl/utf8_decoder_with_replacement_unit.sv
tb/utf8_decoder_with_replacement_unit_test.sv
